// ----- rtl/core/ps2dl_pkg.sv -----
// shared types, codes and constants of the ps2 device link engine
package ps2dl_pkg;

  // default transmit queue depth
  localparam int QUEUE_DEPTH_DEF = 128;

  // configuration register indexes and widths
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 10;
  localparam logic [CFG_IDX_W-1:0] CFG_REPORT_PERIOD = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_HOST_WAIT     = 1'b1;

  // configuration reset values
  localparam logic [9:0] REPORT_PERIOD_RST = 10'd500;
  localparam logic [3:0] HOST_WAIT_RST     = 4'd7;

  // link state codes
  localparam logic [2:0] LM_IDLE    = 3'd0;
  localparam logic [2:0] LM_INHIBIT = 3'd1;
  localparam logic [2:0] LM_BUSY    = 3'd2;
  localparam logic [2:0] LM_WAIT    = 3'd3;
  localparam logic [2:0] LM_REQUEST = 3'd4;

  // clock phase codes
  localparam logic [1:0] PH_RISE = 2'd0;
  localparam logic [1:0] PH_HIGH = 2'd1;
  localparam logic [1:0] PH_FALL = 2'd2;
  localparam logic [1:0] PH_LOW  = 2'd3;

  // frame bit positions
  localparam logic [3:0] BIT_START  = 4'd0;
  localparam logic [3:0] BIT_DATA_L = 4'd1;
  localparam logic [3:0] BIT_DATA_H = 4'd8;
  localparam logic [3:0] BIT_PARITY = 4'd9;
  localparam logic [3:0] BIT_STOP   = 4'd10;
  localparam logic [3:0] BIT_DONE   = 4'd11;

  // input item
  typedef struct packed {
    logic       clk_line;
    logic       data_line;
    logic       push_valid;
    logic [7:0] push_byte;
  } in_item_t;

  // result item
  typedef struct packed {
    logic       clk_drive;
    logic       data_drive;
    logic       rx_valid;
    logic [7:0] rx_byte;
    logic       report_due;
    logic [2:0] link_state;
    logic       resend_flag;
    logic       queue_full;
  } out_item_t;

  // queue update request from the link engine
  typedef struct packed {
    logic       push;
    logic       pop;
    logic [7:0] wr_byte;
  } q_req_t;

endpackage

// ----- rtl/core/ps2_device_link_engine.sv -----
// top level of the ps2 device link engine
// a tick transfer's result is registered in the output buffer (output register or skid stage)
// throughput: one tick per cycle unless in_stall; link registers update in the same cycle
//   and the queue memory prefetches the next head byte with registered read and write bypass
// a two-entry output buffer keeps input transfers going while one result waits
// reset: synchronous active-low; control state clears at once, queue contents are not cleared
module ps2_device_link_engine
  import ps2dl_pkg::*;
#(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  in_item_t              in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output out_item_t             out_data,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  logic             step, buf_full;
  q_req_t           q_req;
  logic [CNT_W-1:0] q_count;
  logic [7:0]       q_head_byte;
  out_item_t        result;

  // tick transfer
  assign in_stall = buf_full;
  assign step     = in_valid & ~buf_full;

  ps2dl_queue #(
    .QUEUE_DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (step),
    .req       (q_req),
    .count     (q_count),
    .head_byte (q_head_byte)
  );

  ps2dl_link #(
    .QUEUE_DEPTH(QUEUE_DEPTH)
  ) u_link (
    .clk         (clk),
    .rst_n       (rst_n),
    .step        (step),
    .in_item     (in_data),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .q_count     (q_count),
    .q_head_byte (q_head_byte),
    .q_req       (q_req),
    .result      (result)
  );

  ps2dl_obuf u_obuf (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (step),
    .load_item (result),
    .full      (buf_full),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

// ----- rtl/core/ps2dl_queue.sv -----
// transmit queue: synchronous memory with head prefetch and write bypass
module ps2dl_queue
  import ps2dl_pkg::*;
#(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               step,
  input  q_req_t                             req,
  output logic [$clog2(QUEUE_DEPTH+1)-1:0]   count,
  output logic [7:0]                         head_byte
);

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);

  logic [7:0]       mem [QUEUE_DEPTH];
  logic [PTR_W-1:0] head_r, tail_r, head_nxt, tail_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [7:0]       rd_r, byp_data_r;
  logic             byp_r;
  logic             do_push, do_pop;

  assign do_push = step & req.push;
  assign do_pop  = step & req.pop;

  // pointer wrap at the queue depth
  always_comb begin
    head_nxt  = head_r;
    tail_nxt  = tail_r;
    count_nxt = count_r;
    if (do_push) begin
      tail_nxt  = (tail_r == PTR_LAST) ? '0 : tail_r + 1'b1;
      count_nxt = count_nxt + 1'b1;
    end
    if (do_pop) begin
      head_nxt  = (head_r == PTR_LAST) ? '0 : head_r + 1'b1;
      count_nxt = count_nxt - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= '0;
      tail_r  <= '0;
      count_r <= '0;
      byp_r   <= 1'b0;
    end else begin
      head_r  <= head_nxt;
      tail_r  <= tail_nxt;
      count_r <= count_nxt;
      byp_r   <= do_push && (tail_r == head_nxt);
    end
  end

  // memory write at tail, registered read at the next head
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[tail_r] <= req.wr_byte;
    end
    rd_r       <= mem[head_nxt];
    byp_data_r <= req.wr_byte;
  end

  assign count     = count_r;
  assign head_byte = byp_r ? byp_data_r : rd_r;

endmodule

// ----- rtl/core/ps2dl_link.sv -----
// per-tick link engine: clock generation, frame shifting, receive and link state machine
module ps2dl_link
  import ps2dl_pkg::*;
#(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               step,
  input  in_item_t                           in_item,
  input  logic                               cfg_we,
  input  logic [CFG_IDX_W-1:0]               cfg_index,
  input  logic [CFG_DATA_W-1:0]              cfg_data,
  input  logic [$clog2(QUEUE_DEPTH+1)-1:0]   q_count,
  input  logic [7:0]                         q_head_byte,
  output q_req_t                             q_req,
  output out_item_t                          result
);

  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

  // configuration
  logic [9:0] report_period_r;
  logic [3:0] host_wait_r;

  // link state
  logic [2:0] mode_r, mode_nxt;
  logic [1:0] phase_r, phase_nxt, next_ph_r, next_ph_nxt;
  logic [3:0] bit_r, bit_nxt;
  logic [7:0] shift_r, shift_nxt, rx_shift_r, rx_shift_nxt;
  logic       par_r, par_nxt;
  logic       tx_act_r, tx_act_nxt, rx_act_r, rx_act_nxt;
  logic [3:0] wait_r, wait_nxt;
  logic [9:0] rep_cnt_r, rep_cnt_nxt;
  logic       rep_flag_r, rep_flag_nxt, resend_r, resend_nxt;
  logic       clk_out_r, clk_out_nxt, data_out_r, data_out_nxt;

  // per-tick scratch
  logic             push_ok, do_high, sensed_high, pop, rx_v;
  logic [CNT_W-1:0] cnt_push, cnt_fin;
  logic [7:0]       rx_b, fetch_byte;

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      report_period_r <= REPORT_PERIOD_RST;
      host_wait_r     <= HOST_WAIT_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_REPORT_PERIOD: report_period_r <= cfg_data;
        CFG_HOST_WAIT:     host_wait_r     <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  // a byte pushed into an empty queue is the head in the same tick
  assign fetch_byte = (q_count == '0) ? in_item.push_byte : q_head_byte;

  always_comb begin
    mode_nxt     = mode_r;
    phase_nxt    = phase_r;
    next_ph_nxt  = next_ph_r;
    bit_nxt      = bit_r;
    shift_nxt    = shift_r;
    rx_shift_nxt = rx_shift_r;
    par_nxt      = par_r;
    tx_act_nxt   = tx_act_r;
    rx_act_nxt   = rx_act_r;
    wait_nxt     = wait_r;
    rep_cnt_nxt  = rep_cnt_r;
    rep_flag_nxt = rep_flag_r;
    resend_nxt   = resend_r;
    clk_out_nxt  = clk_out_r;
    data_out_nxt = data_out_r;
    do_high      = 1'b0;
    pop          = 1'b0;
    rx_v         = 1'b0;
    rx_b         = 8'd0;

    // push, full queue drops the byte
    push_ok  = in_item.push_valid && (q_count != CNT_FULL);
    cnt_push = q_count + CNT_W'(push_ok);
    if (push_ok) begin
      rep_flag_nxt = 1'b0;
      resend_nxt   = 1'b0;
    end

    // report interval counter
    if (cnt_push == '0) begin
      rep_cnt_nxt = rep_cnt_nxt + 10'd1;
    end
    if (rep_cnt_nxt >= report_period_r) begin
      rep_flag_nxt = 1'b1;
      rep_cnt_nxt  = '0;
    end

    // wait countdown
    if (wait_nxt != '0) begin
      wait_nxt = wait_nxt - 4'd1;
    end

    // transmit phase
    cnt_fin = cnt_push;
    if (tx_act_nxt && wait_nxt == '0) begin
      phase_nxt = next_ph_nxt;
      if (phase_nxt == PH_RISE) begin
        if (bit_nxt == BIT_START) begin
          if (cnt_fin != '0) begin
            shift_nxt = fetch_byte;
            pop       = 1'b1;
            cnt_fin   = cnt_fin - 1'b1;
            par_nxt   = ~^fetch_byte;
            wait_nxt  = host_wait_r;
          end
        end else if (bit_nxt == BIT_DONE) begin
          tx_act_nxt = 1'b0;
          bit_nxt    = BIT_START;
        end
        if (wait_nxt == '0) begin
          clk_out_nxt = 1'b1;
          next_ph_nxt = PH_HIGH;
        end else begin
          do_high = 1'b1;
        end
      end
      if (phase_nxt == PH_HIGH || do_high) begin
        case (bit_nxt) inside
          BIT_START: data_out_nxt = 1'b0;
          [BIT_DATA_L:BIT_DATA_H]: begin
            data_out_nxt = shift_nxt[0];
            shift_nxt    = shift_nxt >> 1;
          end
          BIT_PARITY: data_out_nxt = par_nxt;
          BIT_STOP:   data_out_nxt = 1'b1;
          default: ;
        endcase
        bit_nxt     = bit_nxt + 4'd1;
        next_ph_nxt = PH_FALL;
      end else if (phase_nxt == PH_FALL) begin
        clk_out_nxt = 1'b0;
        next_ph_nxt = PH_LOW;
      end else if (phase_nxt == PH_LOW) begin
        next_ph_nxt = PH_RISE;
      end
    end

    // receive phase
    if (rx_act_nxt) begin
      phase_nxt = next_ph_nxt;
      unique case (phase_nxt)
        PH_RISE: begin
          clk_out_nxt = 1'b1;
          if (bit_nxt < BIT_PARITY - 4'd1) begin
            rx_shift_nxt[bit_nxt[2:0]] = rx_shift_nxt[bit_nxt[2:0]] | in_item.data_line;
          end
          if (bit_nxt < BIT_DONE) begin
            next_ph_nxt = PH_HIGH;
            bit_nxt     = bit_nxt + 4'd1;
          end
        end
        PH_HIGH: begin
          if (bit_nxt == BIT_STOP) begin
            data_out_nxt = 1'b0;
          end else if (bit_nxt == BIT_DONE) begin
            data_out_nxt = 1'b1;
            rx_act_nxt   = 1'b0;
            bit_nxt      = BIT_START;
            rx_v         = 1'b1;
            rx_b         = rx_shift_nxt;
            rx_shift_nxt = '0;
          end
          next_ph_nxt = PH_FALL;
        end
        PH_FALL: begin
          clk_out_nxt = 1'b0;
          next_ph_nxt = PH_LOW;
        end
        default: next_ph_nxt = PH_RISE;
      endcase
    end

    // link state machine
    sensed_high = (phase_nxt == PH_HIGH || phase_nxt == PH_RISE) && !in_item.clk_line;
    unique case (mode_r)
      LM_BUSY: begin
        if (sensed_high) begin
          mode_nxt    = LM_INHIBIT;
          next_ph_nxt = PH_LOW;
          tx_act_nxt  = 1'b0;
          rx_act_nxt  = 1'b0;
        end else if (!(tx_act_nxt || rx_act_nxt)) begin
          mode_nxt = LM_IDLE;
        end
      end
      LM_INHIBIT: begin
        if (bit_nxt > BIT_START && bit_nxt < BIT_STOP) begin
          resend_nxt = 1'b1;
        end
        bit_nxt = BIT_START;
        if (in_item.clk_line) begin
          mode_nxt = LM_WAIT;
        end else begin
          mode_nxt    = LM_INHIBIT;
          next_ph_nxt = PH_LOW;
          tx_act_nxt  = 1'b0;
          rx_act_nxt  = 1'b0;
        end
      end
      LM_WAIT: begin
        if (!in_item.data_line) begin
          mode_nxt    = LM_REQUEST;
          next_ph_nxt = PH_RISE;
        end else begin
          mode_nxt = LM_IDLE;
        end
      end
      LM_REQUEST: begin
        rx_act_nxt   = 1'b1;
        tx_act_nxt   = 1'b0;
        bit_nxt      = BIT_START;
        rx_shift_nxt = '0;
        mode_nxt     = LM_BUSY;
      end
      default: begin
        if (sensed_high) begin
          mode_nxt    = LM_INHIBIT;
          next_ph_nxt = PH_LOW;
          tx_act_nxt  = 1'b0;
          rx_act_nxt  = 1'b0;
        end else if (cnt_fin != '0) begin
          mode_nxt    = LM_BUSY;
          tx_act_nxt  = 1'b1;
          rx_act_nxt  = 1'b0;
          next_ph_nxt = PH_RISE;
          bit_nxt     = BIT_START;
        end else begin
          mode_nxt = LM_IDLE;
        end
      end
    endcase
  end

  // state update on each accepted tick
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r     <= LM_IDLE;
      phase_r    <= PH_RISE;
      next_ph_r  <= PH_RISE;
      bit_r      <= BIT_START;
      shift_r    <= '0;
      rx_shift_r <= '0;
      par_r      <= 1'b0;
      tx_act_r   <= 1'b0;
      rx_act_r   <= 1'b0;
      wait_r     <= '0;
      rep_cnt_r  <= '0;
      rep_flag_r <= 1'b0;
      resend_r   <= 1'b0;
      clk_out_r  <= 1'b1;
      data_out_r <= 1'b1;
    end else if (step) begin
      mode_r     <= mode_nxt;
      phase_r    <= phase_nxt;
      next_ph_r  <= next_ph_nxt;
      bit_r      <= bit_nxt;
      shift_r    <= shift_nxt;
      rx_shift_r <= rx_shift_nxt;
      par_r      <= par_nxt;
      tx_act_r   <= tx_act_nxt;
      rx_act_r   <= rx_act_nxt;
      wait_r     <= wait_nxt;
      rep_cnt_r  <= rep_cnt_nxt;
      rep_flag_r <= rep_flag_nxt;
      resend_r   <= resend_nxt;
      clk_out_r  <= clk_out_nxt;
      data_out_r <= data_out_nxt;
    end
  end

  // queue request and tick result
  always_comb begin
    q_req.push    = push_ok;
    q_req.pop     = pop;
    q_req.wr_byte = in_item.push_byte;

    result.clk_drive   = clk_out_nxt;
    result.data_drive  = data_out_nxt;
    result.rx_valid    = rx_v;
    result.rx_byte     = rx_b;
    result.report_due  = rep_flag_nxt;
    result.link_state  = mode_nxt;
    result.resend_flag = resend_nxt;
    result.queue_full  = (cnt_fin == CNT_FULL);
  end

endmodule

// ----- rtl/core/ps2dl_obuf.sv -----
// two-entry result buffer: output register plus skid stage
module ps2dl_obuf
  import ps2dl_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      load,
  input  out_item_t load_item,
  output logic      full,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  logic      main_v_r, skid_v_r;
  out_item_t main_r, skid_r;
  logic      take;

  assign take = main_v_r & ~out_stall;

  // valid flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_v_r <= 1'b0;
      skid_v_r <= 1'b0;
    end else if (skid_v_r) begin
      if (take) begin
        skid_v_r <= 1'b0;
      end
    end else if (load) begin
      if (main_v_r && !take) begin
        skid_v_r <= 1'b1;
      end else begin
        main_v_r <= 1'b1;
      end
    end else if (take) begin
      main_v_r <= 1'b0;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (skid_v_r) begin
      if (take) begin
        main_r <= skid_r;
      end
    end else if (load) begin
      if (main_v_r && !take) begin
        skid_r <= load_item;
      end else begin
        main_r <= load_item;
      end
    end
  end

  assign full      = skid_v_r;
  assign out_valid = main_v_r;
  assign out_data  = main_r;

endmodule

// ----- rtl/core/ps2dl_checker.sv -----
// port-level checker of the ps2 device link engine and its bind
module ps2dl_checker
  import ps2dl_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      out_valid,
  input logic      out_stall,
  input out_item_t out_data
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  // no result straight after reset
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result shown after reset");

  // received byte is zero unless a byte completed
  a_rx_byte_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.rx_valid |-> out_data.rx_byte == 8'd0)
    else $error("rx byte without rx valid");

  // a completed host byte releases data and leaves the busy state
  a_rx_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.rx_valid |->
      out_data.data_drive &&
      (out_data.link_state == LM_IDLE || out_data.link_state == LM_INHIBIT))
    else $error("rx completion with wrong line or state");

endmodule

bind ps2_device_link_engine ps2dl_checker u_ps2dl_checker (.*);
